// ===== rtl/bcd_clock_setter_with_alarm_defines.svh =====
// Assertion macros used by the clock setter core.
// Define ASSERT_OFF to compile the checks out.
`ifndef BCD_CLOCK_SETTER_WITH_ALARM_DEFINES_SVH
`define BCD_CLOCK_SETTER_WITH_ALARM_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, off during reset
`define BCSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication, off during reset
`define BCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define BCSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bcsa_pkg.sv =====
// Types, codes, wrap limits and the BCD increment helper for the clock setter.
// No dependencies; every other RTL file but the defines header uses it by scoped names.
package bcsa_pkg;

	typedef enum logic [2:0] {
		CMD_SNAP      = 3'd0,
		CMD_INC       = 3'd1,
		CMD_NEXT      = 3'd2,
		CMD_TIME_SET  = 3'd3,
		CMD_ALARM_SET = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE         = 4'd0,
		ST_YEAR         = 4'd1,
		ST_MONTH        = 4'd2,
		ST_DATE         = 4'd3,
		ST_WEEKDAY      = 4'd4,
		ST_HOUR         = 4'd5,
		ST_MINUTE       = 4'd6,
		ST_ALARM_HOUR   = 4'd7,
		ST_ALARM_MINUTE = 4'd8
	} edit_t;

	typedef enum logic [1:0] {
		IND_BLANK   = 2'd0,
		IND_ARMED   = 2'd1,
		IND_RINGING = 2'd2
	} ind_t;

	// increment wrap points (raw BCD-coded compare values)
	localparam logic [7:0] YEAR_WRAP      = 8'd41;
	localparam logic [7:0] MONTH_WRAP     = 8'd19;
	localparam logic [7:0] HOUR_WRAP      = 8'd36;
	localparam logic [7:0] MINUTE_WRAP    = 8'd96;
	localparam logic [7:0] DATE_WRAP_FEB  = 8'd41;
	localparam logic [7:0] DATE_WRAP_LEAP = 8'd48;
	localparam logic [7:0] DATE_WRAP_30   = 8'd49;
	localparam logic [7:0] DATE_WRAP_31   = 8'd50;

	localparam logic [4:0] MONTH_FEB = 5'h02;
	localparam logic [4:0] MONTH_APR = 5'h04;
	localparam logic [4:0] MONTH_JUN = 5'h06;
	localparam logic [4:0] MONTH_SEP = 5'h09;
	localparam logic [4:0] MONTH_NOV = 5'h11;

	localparam logic [6:0] SEC_LAST     = 7'd88;
	localparam logic [2:0] WEEKDAY_LAST = 3'd7;
	localparam logic [2:0] WEEKDAY_FIRST = 3'd1;
	localparam logic [7:0] YEAR_RESET   = 8'h14;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] snap_second;
		logic [6:0] snap_minute;
		logic [5:0] snap_hour;
		logic [2:0] snap_weekday;
		logic [5:0] snap_date;
		logic [4:0] snap_month;
		logic [7:0] snap_year;
	} in_item_t;

	typedef struct packed {
		logic [3:0] edit_field;
		logic [7:0] year_out;
		logic [4:0] month_out;
		logic [5:0] date_out;
		logic [2:0] weekday_out;
		logic [5:0] hour_out;
		logic [6:0] minute_out;
		logic [5:0] alarm_hour_out;
		logic [6:0] alarm_minute_out;
		logic       beep;
		logic [1:0] indicator;
		logic       write_time;
	} out_item_t;

	// input register contents handed to the update logic
	typedef struct packed {
		logic     valid;
		in_item_t data;
	} stage_t;

	// BCD increment: carry into tens on a ones digit of nine or more,
	// then wrap to first once the result reaches limit
	function automatic logic [7:0] bcd_next(input logic [7:0] v, input logic [7:0] limit,
			input logic [7:0] first);
		logic [8:0] r;
		if (v[3:0] >= 4'd9) begin
			r = {1'b0, v[7:4], 4'h0} + 9'h010;
		end else begin
			r = {1'b0, v} + 9'd1;
		end
		return (r >= {1'b0, limit}) ? first : r[7:0];
	endfunction

endpackage

// ===== rtl/bcsa_item_if.sv =====
// Input channel of the clock setter: valid/ready plus one command item.
// Depends on bcsa_pkg.
interface bcsa_item_if;
	logic               valid;
	logic               ready;
	bcsa_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/bcsa_result_if.sv =====
// Result channel of the clock setter: valid/ready plus one field snapshot.
// Depends on bcsa_pkg.
interface bcsa_result_if;
	logic                valid;
	logic                ready;
	bcsa_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/bcsa_in_stage.sv =====
// Input register of the clock setter; holds one command until the update runs.
// Depends on bcsa_pkg and bcsa_item_if.
module bcsa_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	bcsa_item_if.sink        item,
	input  logic             advance,
	output bcsa_pkg::stage_t s1
);

	logic               valid_s1;
	bcsa_pkg::in_item_t data_s1;

	// free when empty or when the held command moves on this cycle
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			data_s1 <= item.data;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.data  = data_s1;

endmodule

// ===== rtl/bcsa_core.sv =====
// Field registers, edit sequencer, alarm compare and BCD increment logic.
// Depends on bcsa_pkg and bcd_clock_setter_with_alarm_defines.svh.
`include "bcd_clock_setter_with_alarm_defines.svh"

module bcsa_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  bcsa_pkg::in_item_t  cmd_item,
	output bcsa_pkg::out_item_t result_d
);

	bcsa_pkg::edit_t step_q, step_d;
	bcsa_pkg::ind_t  ind_q, ind_d;
	logic [7:0] year_q, year_d;
	logic [4:0] month_q, month_d;
	logic [5:0] date_q, date_d;
	logic [2:0] weekday_q, weekday_d;
	logic [5:0] hour_q, hour_d;
	logic [6:0] minute_q, minute_d;
	logic [5:0] alarm_hour_q, alarm_hour_d;
	logic [6:0] alarm_minute_q, alarm_minute_d;
	logic       beep_q, beep_d;
	logic       write_time;

	logic [7:0] year_inc, month_inc, date_inc, hour_inc, minute_inc;
	logic [7:0] alarm_hour_inc, alarm_minute_inc;
	logic [5:0] leap_sum;
	logic       leap;
	logic [7:0] date_wrap;

	// tens*10 + ones is divisible by four exactly when tens*2 + ones is
	assign leap_sum = {1'b0, year_q[7:4], 1'b0} + {2'b00, year_q[3:0]};
	assign leap     = (leap_sum[1:0] == 2'b00);

	always_comb begin
		if (month_q == bcsa_pkg::MONTH_FEB) begin
			date_wrap = leap ? bcsa_pkg::DATE_WRAP_LEAP : bcsa_pkg::DATE_WRAP_FEB;
		end else if (month_q inside {bcsa_pkg::MONTH_APR, bcsa_pkg::MONTH_JUN,
				bcsa_pkg::MONTH_SEP, bcsa_pkg::MONTH_NOV}) begin
			date_wrap = bcsa_pkg::DATE_WRAP_30;
		end else begin
			date_wrap = bcsa_pkg::DATE_WRAP_31;
		end
	end

	assign year_inc   = bcsa_pkg::bcd_next(year_q, bcsa_pkg::YEAR_WRAP, 8'd0);
	assign month_inc  = bcsa_pkg::bcd_next({3'b000, month_q}, bcsa_pkg::MONTH_WRAP, 8'd1);
	assign date_inc   = bcsa_pkg::bcd_next({2'b00, date_q}, date_wrap, 8'd1);
	assign hour_inc   = bcsa_pkg::bcd_next({2'b00, hour_q}, bcsa_pkg::HOUR_WRAP, 8'd0);
	assign minute_inc = bcsa_pkg::bcd_next({1'b0, minute_q}, bcsa_pkg::MINUTE_WRAP, 8'd0);
	assign alarm_hour_inc =
		bcsa_pkg::bcd_next({2'b00, alarm_hour_q}, bcsa_pkg::HOUR_WRAP, 8'd0);
	assign alarm_minute_inc =
		bcsa_pkg::bcd_next({1'b0, alarm_minute_q}, bcsa_pkg::MINUTE_WRAP, 8'd0);

	always_comb begin
		step_d         = step_q;
		ind_d          = ind_q;
		year_d         = year_q;
		month_d        = month_q;
		date_d         = date_q;
		weekday_d      = weekday_q;
		hour_d         = hour_q;
		minute_d       = minute_q;
		alarm_hour_d   = alarm_hour_q;
		alarm_minute_d = alarm_minute_q;
		beep_d         = beep_q;
		write_time     = 1'b0;
		if (fire) begin
			case (cmd_item.command)
				bcsa_pkg::CMD_SNAP: begin
					// snapshots are dropped while a field is being edited
					if (step_q == bcsa_pkg::ST_IDLE) begin
						minute_d  = cmd_item.snap_minute;
						hour_d    = cmd_item.snap_hour;
						weekday_d = cmd_item.snap_weekday;
						date_d    = cmd_item.snap_date;
						month_d   = cmd_item.snap_month;
						year_d    = cmd_item.snap_year;
						if (cmd_item.snap_hour == alarm_hour_q &&
								cmd_item.snap_minute == alarm_minute_q) begin
							ind_d  = (cmd_item.snap_second > bcsa_pkg::SEC_LAST) ?
								bcsa_pkg::IND_BLANK : bcsa_pkg::IND_RINGING;
							beep_d = 1'b1;
						end else begin
							beep_d = 1'b0;
						end
					end
				end
				bcsa_pkg::CMD_INC: begin
					case (step_q)
						bcsa_pkg::ST_YEAR:    year_d   = year_inc;
						bcsa_pkg::ST_MONTH:   month_d  = month_inc[4:0];
						bcsa_pkg::ST_DATE:    date_d   = date_inc[5:0];
						bcsa_pkg::ST_WEEKDAY: begin
							weekday_d = (weekday_q >= bcsa_pkg::WEEKDAY_LAST) ?
								bcsa_pkg::WEEKDAY_FIRST : weekday_q + 3'd1;
						end
						bcsa_pkg::ST_HOUR:    hour_d   = hour_inc[5:0];
						bcsa_pkg::ST_MINUTE:  minute_d = minute_inc[6:0];
						bcsa_pkg::ST_ALARM_HOUR: begin
							// mirror the alarm field into the time display field
							alarm_hour_d = alarm_hour_inc[5:0];
							hour_d       = alarm_hour_inc[5:0];
						end
						bcsa_pkg::ST_ALARM_MINUTE: begin
							alarm_minute_d = alarm_minute_inc[6:0];
							minute_d       = alarm_minute_inc[6:0];
						end
						default: ;
					endcase
				end
				bcsa_pkg::CMD_NEXT: begin
					case (step_q)
						bcsa_pkg::ST_YEAR, bcsa_pkg::ST_MONTH, bcsa_pkg::ST_DATE,
						bcsa_pkg::ST_WEEKDAY, bcsa_pkg::ST_HOUR: begin
							step_d = bcsa_pkg::edit_t'(step_q + 4'd1);
						end
						bcsa_pkg::ST_MINUTE: begin
							step_d     = bcsa_pkg::ST_IDLE;
							write_time = 1'b1;
						end
						bcsa_pkg::ST_ALARM_HOUR: step_d = bcsa_pkg::ST_ALARM_MINUTE;
						bcsa_pkg::ST_ALARM_MINUTE: begin
							step_d = bcsa_pkg::ST_IDLE;
							ind_d  = bcsa_pkg::IND_ARMED;
						end
						default: ;
					endcase
				end
				bcsa_pkg::CMD_TIME_SET: begin
					if (step_q == bcsa_pkg::ST_IDLE) begin
						step_d = bcsa_pkg::ST_YEAR;
						ind_d  = bcsa_pkg::IND_BLANK;
					end
				end
				bcsa_pkg::CMD_ALARM_SET: begin
					if (step_q == bcsa_pkg::ST_IDLE) begin
						step_d         = bcsa_pkg::ST_ALARM_HOUR;
						alarm_hour_d   = 6'd0;
						alarm_minute_d = 7'd0;
						hour_d         = 6'd0;
						minute_d       = 7'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= bcsa_pkg::ST_IDLE;
			ind_q          <= bcsa_pkg::IND_BLANK;
			year_q         <= bcsa_pkg::YEAR_RESET;
			month_q        <= 5'd1;
			date_q         <= 6'd1;
			weekday_q      <= bcsa_pkg::WEEKDAY_FIRST;
			hour_q         <= 6'd0;
			minute_q       <= 7'd0;
			alarm_hour_q   <= 6'd0;
			alarm_minute_q <= 7'd0;
			beep_q         <= 1'b0;
		end else begin
			step_q         <= step_d;
			ind_q          <= ind_d;
			year_q         <= year_d;
			month_q        <= month_d;
			date_q         <= date_d;
			weekday_q      <= weekday_d;
			hour_q         <= hour_d;
			minute_q       <= minute_d;
			alarm_hour_q   <= alarm_hour_d;
			alarm_minute_q <= alarm_minute_d;
			beep_q         <= beep_d;
		end
	end

	assign result_d.edit_field       = step_d;
	assign result_d.year_out         = year_d;
	assign result_d.month_out        = month_d;
	assign result_d.date_out         = date_d;
	assign result_d.weekday_out      = weekday_d;
	assign result_d.hour_out         = hour_d;
	assign result_d.minute_out       = minute_d;
	assign result_d.alarm_hour_out   = alarm_hour_d;
	assign result_d.alarm_minute_out = alarm_minute_d;
	assign result_d.beep             = beep_d;
	assign result_d.indicator        = ind_d;
	assign result_d.write_time       = write_time;

	`BCSA_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !fire, $stable(step_q) && $stable(ind_q) && $stable(alarm_hour_q))
	`BCSA_ASSERT_NOW(a_write_ends_set, clk, arst_n, fire && write_time, step_q == bcsa_pkg::ST_MINUTE && step_d == bcsa_pkg::ST_IDLE)
	`BCSA_ASSERT_NEXT(a_snap_dropped_in_edit, clk, arst_n, fire && cmd_item.command == bcsa_pkg::CMD_SNAP && step_q != bcsa_pkg::ST_IDLE, $stable(beep_q) && $stable(year_q))
	`BCSA_ASSERT_NEXT(a_alarm_edit_mirrors, clk, arst_n, fire && cmd_item.command == bcsa_pkg::CMD_INC && step_q == bcsa_pkg::ST_ALARM_HOUR, hour_q == alarm_hour_q)

endmodule

// ===== rtl/bcsa_out_reg.sv =====
// Result register of the clock setter; holds one result until it is taken.
// Depends on bcsa_pkg and bcsa_result_if.
module bcsa_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bcsa_pkg::out_item_t load_data,
	output logic                free,
	bcsa_result_if.source       result
);

	logic                valid_q;
	bcsa_pkg::out_item_t data_q;

	// a new result may enter while the current one transfers
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= load_data;
		end
	end

	assign result.valid = valid_q;
	assign result.data  = data_q;

endmodule

// ===== rtl/bcd_clock_setter_with_alarm.sv =====
// Top level of the BCD clock setter with alarm: input register, update logic,
// result register. Depends on bcsa_pkg, bcsa_item_if, bcsa_result_if and the submodules.
//
//   channel   dir   payload                                  handshake
//   item      in    command, snap_second .. snap_year        valid/ready
//   result    out   edit_field .. indicator, write_time      valid/ready
//
// One command per cycle unless the result side stalls; each command gives one result.
// The rate is set by the field registers, which update in the same cycle a command
// leaves the input register and its result enters the result register.
// arst_n clears the fields to their reset values and both stages to empty.
// A stalled result register holds the input register; the input side stalls once both are full.
module bcd_clock_setter_with_alarm (
	input  logic          clk,
	input  logic          arst_n,
	bcsa_item_if.sink     item,
	bcsa_result_if.source result
);

	bcsa_pkg::stage_t    s1;
	bcsa_pkg::out_item_t result_d;
	logic                out_free;
	logic                advance;

	assign advance = s1.valid && out_free;

	bcsa_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.advance (advance),
		.s1      (s1)
	);

	bcsa_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.cmd_item (s1.data),
		.result_d (result_d)
	);

	bcsa_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_data (result_d),
		.free      (out_free),
		.result    (result)
	);

endmodule
